### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files that check themselves.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/plint_pkg.sv
// Types and constants of the piecewise linear interpolator.
// No dependencies; used by plint_ctrl, plint_dp and the top level.
`default_nettype none

package plint_pkg;

	localparam int DATA_W    = 32;
	localparam int COUNT_W   = 7;
	localparam int PROD_W    = 64;
	// quotient bits worth computing; anything at or above 2^QUO_BITS saturates
	localparam int QUO_BITS  = 34;
	localparam int DIV_CNT_W = 6;
	localparam int SUM_W     = QUO_BITS + 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] REG_POINT_COUNT = 2'd0;

	localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 7'd1;

	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_DIFF,
		ST_MUL,
		ST_DIV_PRE,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic capture_q;
		logic rd_en;
		logic take;
		logic first;
		logic diff;
		logic mul;
		logic div_pre;
		logic div_step;
		logic emit_load;
		logic emit_query;
	} cmd_t;

	typedef struct packed {
		logic flat;
	} status_t;

endpackage

`default_nettype wire

### hw/rtl/plint_ctrl.sv
// Controller of the interpolator: sequences load, scan, multiply and divide.
// Depends on plint_pkg; drives plint_dp through cmd_t.
`default_nettype none

module plint_ctrl #(
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                op,
	input  wire logic [CW-1:0]       n_eff,
	input  wire plint_pkg::status_t  status,
	output logic                     busy,
	output logic                     strobe,
	output plint_pkg::cmd_t          cmd,
	output logic [AW-1:0]            rd_addr
);

	plint_pkg::state_t state_q, state_d;
	logic [AW-1:0] scan_cnt_q;
	logic [plint_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic take_s1, first_s1, strobe_q;
	logic [AW-1:0] last_addr;

	assign last_addr = AW'(n_eff - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= plint_pkg::ST_IDLE;
			scan_cnt_q <= '0;
			div_cnt_q  <= '0;
			take_s1    <= 1'b0;
			first_s1   <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			take_s1  <= cmd.rd_en;
			first_s1 <= cmd.rd_en && (scan_cnt_q == '0);
			strobe_q <= cmd.emit_load | cmd.emit_query;
			if (state_q == plint_pkg::ST_IDLE)
				scan_cnt_q <= '0;
			else if (cmd.rd_en)
				scan_cnt_q <= scan_cnt_q + 1'b1;
			if (cmd.div_pre)
				div_cnt_q <= plint_pkg::DIV_CNT_W'(plint_pkg::QUO_BITS - 1);
			else if (cmd.div_step)
				div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.take  = take_s1;
		cmd.first = first_s1;
		case (state_q)
			plint_pkg::ST_IDLE: begin
				if (start) begin
					if (op == plint_pkg::OP_LOAD) begin
						cmd.wr_en     = 1'b1;
						cmd.emit_load = 1'b1;
					end else begin
						cmd.capture_q = 1'b1;
						state_d       = plint_pkg::ST_SCAN;
					end
				end
			end
			plint_pkg::ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (scan_cnt_q == last_addr)
					state_d = plint_pkg::ST_SCAN_END;
			end
			plint_pkg::ST_SCAN_END: begin
				state_d = plint_pkg::ST_DIFF;
			end
			plint_pkg::ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = plint_pkg::ST_MUL;
			end
			plint_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				// equal bracket abscissae need no division
				state_d = status.flat ? plint_pkg::ST_FINISH : plint_pkg::ST_DIV_PRE;
			end
			plint_pkg::ST_DIV_PRE: begin
				cmd.div_pre = 1'b1;
				state_d     = plint_pkg::ST_DIV;
			end
			plint_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == '0)
					state_d = plint_pkg::ST_FINISH;
			end
			plint_pkg::ST_FINISH: begin
				cmd.emit_query = 1'b1;
				state_d        = plint_pkg::ST_IDLE;
			end
			default: begin
				state_d = plint_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy    = (state_q != plint_pkg::ST_IDLE);
	assign strobe  = strobe_q;
	assign rd_addr = scan_cnt_q;

endmodule

`default_nettype wire

### hw/rtl/plint_dp.sv
// Datapath of the interpolator: breakpoint memories, bracket scan,
// multiplier, radix-2 divider and saturating output. Depends on plint_pkg.
`default_nettype none

module plint_dp #(
	parameter int MAX_POINTS = 64,
	parameter int AW = 6
) (
	input  wire logic                        clk,
	input  wire plint_pkg::cmd_t             cmd,
	input  wire logic [AW-1:0]               rd_addr,
	input  wire logic [5:0]                  point_index,
	input  wire logic signed [31:0]          point_x,
	input  wire logic signed [31:0]          point_y,
	input  wire logic signed [31:0]          query_x,
	output plint_pkg::status_t               status,
	output logic signed [31:0]               result_y,
	output logic                             is_query_result,
	output logic                             saturated
);

	localparam int QB = plint_pkg::QUO_BITS;
	localparam int PW = plint_pkg::PROD_W;
	localparam int SW = plint_pkg::SUM_W;

	logic signed [31:0] x_mem [MAX_POINTS];
	logic signed [31:0] y_mem [MAX_POINTS];

	logic signed [31:0] x_rd_s1, y_rd_s1;
	logic signed [31:0] q_q, x_up_q, y_up_q, x_lo_q, y_lo_q;
	logic has_up_q, has_lo_q;
	logic [31:0] dy_mag_q, dq_mag_q, dx_mag_q;
	logic neg_q, eq_q, big_q;
	logic [PW-1:0] prod_q;
	logic [31:0] rem_q;
	logic [QB-1:0] low_q, quo_q;
	logic signed [31:0] result_y_q;
	logic is_query_q, sat_q;

	logic wr_ok;
	logic above;
	logic signed [32:0] dy_w, dq_w, dx_w;
	logic [32:0] trial;
	logic fits;
	logic [31:0] rem_next;
	logic signed [SW-1:0] sq, sum;
	logic [SW-1:0] quo_ext;

	assign wr_ok = (32'(point_index) < MAX_POINTS);

	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			x_mem[AW'(point_index)] <= point_x;
			y_mem[AW'(point_index)] <= point_y;
		end
		if (cmd.rd_en) begin
			x_rd_s1 <= x_mem[rd_addr];
			y_rd_s1 <= y_mem[rd_addr];
		end
	end

	// bracket scan, one entry a beat
	assign above = (x_rd_s1 > q_q);

	always_ff @(posedge clk) begin
		if (cmd.capture_q)
			q_q <= query_x;
		if (cmd.take) begin
			if (cmd.first) begin
				x_up_q   <= x_rd_s1;
				y_up_q   <= y_rd_s1;
				x_lo_q   <= x_rd_s1;
				y_lo_q   <= y_rd_s1;
				has_up_q <= above;
				has_lo_q <= !above;
			end else if (above) begin
				if (!has_up_q || (x_rd_s1 < x_up_q)) begin
					x_up_q <= x_rd_s1;
					y_up_q <= y_rd_s1;
				end
				has_up_q <= 1'b1;
				// no lower point yet: lower follows the maximum x
				if (!has_lo_q && (x_rd_s1 > x_lo_q)) begin
					x_lo_q <= x_rd_s1;
					y_lo_q <= y_rd_s1;
				end
			end else begin
				if (!has_lo_q || (x_rd_s1 > x_lo_q)) begin
					x_lo_q <= x_rd_s1;
					y_lo_q <= y_rd_s1;
				end
				has_lo_q <= 1'b1;
				// no upper point yet: upper follows the last minimum x
				if (!has_up_q && (x_rd_s1 <= x_up_q)) begin
					x_up_q <= x_rd_s1;
					y_up_q <= y_rd_s1;
				end
			end
		end
	end

	assign dy_w = {y_up_q[31], y_up_q} - {y_lo_q[31], y_lo_q};
	assign dq_w = {q_q[31], q_q} - {x_lo_q[31], x_lo_q};
	assign dx_w = {x_up_q[31], x_up_q} - {x_lo_q[31], x_lo_q};

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			dy_mag_q <= dy_w[32] ? 32'(-dy_w) : dy_w[31:0];
			dq_mag_q <= dq_w[32] ? 32'(-dq_w) : dq_w[31:0];
			dx_mag_q <= dx_w[32] ? 32'(-dx_w) : dx_w[31:0];
			neg_q    <= dy_w[32] ^ dq_w[32] ^ dx_w[32];
			eq_q     <= (x_up_q == x_lo_q);
		end
		if (cmd.mul)
			prod_q <= dy_mag_q * dq_mag_q;
	end

	assign status.flat = eq_q;

	// restoring division, one quotient bit a beat
	assign trial    = {rem_q, low_q[QB-1]};
	assign fits     = (trial >= {1'b0, dx_mag_q});
	assign rem_next = fits ? 32'(trial - {1'b0, dx_mag_q}) : trial[31:0];

	always_ff @(posedge clk) begin
		if (cmd.div_pre) begin
			// high part at or above the divisor: quotient >= 2^QB, saturates
			big_q <= (32'(prod_q[PW-1:QB]) >= dx_mag_q);
			rem_q <= 32'(prod_q[PW-1:QB]);
			low_q <= prod_q[QB-1:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			low_q <= {low_q[QB-2:0], 1'b0};
			quo_q <= {quo_q[QB-2:0], fits};
		end
	end

	assign quo_ext = SW'(quo_q);
	assign sq      = neg_q ? -$signed(quo_ext) : $signed(quo_ext);
	assign sum     = SW'(y_lo_q) + sq;

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			result_y_q <= '0;
			is_query_q <= 1'b0;
			sat_q      <= 1'b0;
		end else if (cmd.emit_query) begin
			is_query_q <= 1'b1;
			if (eq_q) begin
				result_y_q <= y_up_q;
				sat_q      <= 1'b0;
			end else if (big_q) begin
				result_y_q <= neg_q ? plint_pkg::Q_MIN : plint_pkg::Q_MAX;
				sat_q      <= 1'b1;
			end else if (sum > SW'(plint_pkg::Q_MAX)) begin
				result_y_q <= plint_pkg::Q_MAX;
				sat_q      <= 1'b1;
			end else if (sum < SW'(plint_pkg::Q_MIN)) begin
				result_y_q <= plint_pkg::Q_MIN;
				sat_q      <= 1'b1;
			end else begin
				result_y_q <= sum[31:0];
				sat_q      <= 1'b0;
			end
		end
	end

	assign result_y        = result_y_q;
	assign is_query_result = is_query_q;
	assign saturated       = sat_q;

endmodule

`default_nettype wire

### hw/rtl/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator: APB register, controller, datapath.
// Depends on plint_pkg, plint_ctrl, plint_dp and assert_macros.svh.
//
//   channel   handshake                      payload
//   command   start / busy                   op, point_index, point_x, point_y, query_x
//   result    strobe (one cycle, no stall)   result_y, is_query_result, saturated
//   config    APB psel/penable/pwrite        paddr, pwdata, prdata (point_count at 0x0)
//
// A load is accepted and written in its accept cycle and acknowledged in the next, with no busy cycle.
// A query scans the n entries in use, with n the point count in use, one beat per entry through
// the memory read port, then runs one multiply and a 34-step radix-2 divider; the divider is
// skipped when the bracket x values are equal. Reset is asynchronous, active low; the
// memories are not cleared. The user must see that they read only what was written; the block
// itself does not enforce it. Results cannot stall.
`default_nettype none
`include "assert_macros.svh"

module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                op,
	input  wire logic [5:0]          point_index,
	input  wire logic signed [31:0]  point_x,
	input  wire logic signed [31:0]  point_y,
	input  wire logic signed [31:0]  query_x,
	output logic                     strobe,
	output logic signed [31:0]       result_y,
	output logic                     is_query_result,
	output logic                     saturated,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [1:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [plint_pkg::COUNT_W-1:0] point_count_q;
	logic [31:0] count_w;
	logic [31:0] n_clamped;
	logic [CW-1:0] n_eff;
	plint_pkg::cmd_t cmd;
	plint_pkg::status_t status;
	logic [AW-1:0] rd_addr;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= plint_pkg::POINT_COUNT_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr == plint_pkg::REG_POINT_COUNT) begin
			point_count_q <= pwdata[plint_pkg::COUNT_W-1:0];
		end
	end

	assign prdata = (paddr == plint_pkg::REG_POINT_COUNT) ? 32'(point_count_q) : '0;

	// zero counts as one, anything past the table as the table size
	assign count_w = 32'(point_count_q);
	always_comb begin
		if (count_w == '0)
			n_clamped = 32'd1;
		else if (count_w > MAX_POINTS)
			n_clamped = 32'(MAX_POINTS);
		else
			n_clamped = count_w;
	end
	assign n_eff = CW'(n_clamped);

	plint_ctrl #(
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.op(op),
		.n_eff(n_eff),
		.status(status),
		.busy(busy),
		.strobe(strobe),
		.cmd(cmd),
		.rd_addr(rd_addr)
	);

	plint_dp #(
		.MAX_POINTS(MAX_POINTS),
		.AW(AW)
	) u_dp (
		.clk(clk),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.point_index(point_index),
		.point_x(point_x),
		.point_y(point_y),
		.query_x(query_x),
		.status(status),
		.result_y(result_y),
		.is_query_result(is_query_result),
		.saturated(saturated)
	);

	`ASSERT_NEXT(a_load_ack, clk, arst_n, start && !busy && op == plint_pkg::OP_LOAD, strobe && !is_query_result && !saturated, "load beat not acknowledged next cycle")
	`ASSERT_NEXT(a_query_busy, clk, arst_n, start && !busy && op == plint_pkg::OP_QUERY, busy && !strobe, "query beat did not start work")
	`ASSERT_IMPLIES(a_sat_query, clk, arst_n, strobe && saturated, is_query_result, "saturation flagged on a load acknowledge")
	`ASSERT_IMPLIES(a_emit_one, clk, arst_n, cmd.emit_query, !cmd.emit_load && busy, "query result issued outside a query")

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for piecewise_linear_interpolator: APB point count, loads and queries.
// Depends on plint_pkg and the RTL; predicts every answer and checks each result beat.
`timescale 1ns / 1ps

module tb_top;

	localparam int SLOTS = 64;
	localparam logic [1:0] COUNT_ADDR = 2'(4 * plint_pkg::REG_POINT_COUNT);

	typedef struct packed {
		logic signed [31:0] y;
		logic               is_query;
		logic               sat;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic op;
	logic [5:0] point_index;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] query_x;
	logic strobe;
	logic signed [31:0] result_y;
	logic is_query_result;
	logic saturated;
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// predictor state
	logic signed [31:0] knot_x[SLOTS];
	logic signed [31:0] knot_y[SLOTS];
	logic [6:0] count_reg = plint_pkg::POINT_COUNT_RESET;
	answer_t pending_answers[$];
	answer_t want;
	int mismatch_count = 0;
	int items_sent = 0;
	bit gaps_on = 1'b1;

	piecewise_linear_interpolator dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.point_index(point_index),
		.point_x(point_x),
		.point_y(point_y),
		.query_x(query_x),
		.strobe(strobe),
		.result_y(result_y),
		.is_query_result(is_query_result),
		.saturated(saturated),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic int slots_in_use();
		if (count_reg == 0)
			return 1;
		if (count_reg > SLOTS)
			return SLOTS;
		return int'(count_reg);
	endfunction

	function automatic answer_t interpolate_at(input logic signed [31:0] q);
		answer_t a;
		int n, up, lo;
		bit has_up, has_lo, neg;
		longint v, dy, dq, dx, sq, sum;
		longint unsigned mdy, mdq, mdx, prod, quo;
		a.is_query = 1'b1;
		a.sat = 1'b0;
		n = slots_in_use();
		up = 0;
		lo = 0;
		has_up = 0;
		has_lo = 0;
		// lower = largest x not above q, upper = smallest x above q; fallbacks give the extremes
		for (int i = 0; i < n; i++) begin
			v = longint'(knot_x[i]);
			if (v > longint'(q)) begin
				if (has_up) begin
					if (v < longint'(knot_x[up]))
						up = i;
				end else begin
					has_up = 1;
					up = i;
				end
				if (!has_lo && v > longint'(knot_x[lo]))
					lo = i;
			end else begin
				if (has_lo) begin
					if (v > longint'(knot_x[lo]))
						lo = i;
				end else begin
					has_lo = 1;
					lo = i;
				end
				if (!has_up && v <= longint'(knot_x[up]))
					up = i;
			end
		end
		if (knot_x[up] == knot_x[lo]) begin
			a.y = knot_y[up];
		end else begin
			dy = longint'(knot_y[up]) - longint'(knot_y[lo]);
			dq = longint'(q) - longint'(knot_x[lo]);
			dx = longint'(knot_x[up]) - longint'(knot_x[lo]);
			neg = ((dy < 0) != (dq < 0)) != (dx < 0);
			mdy = (dy < 0) ? -dy : dy;
			mdq = (dq < 0) ? -dq : dq;
			mdx = (dx < 0) ? -dx : dx;
			prod = mdy * mdq;
			quo = prod / mdx;
			if (quo > (64'd1 << 40))
				quo = 64'd1 << 40;
			sq = neg ? -$signed(quo) : $signed(quo);
			if (prod == 0)
				sq = 0;
			sum = longint'(knot_y[lo]) + sq;
			if (sum > longint'(plint_pkg::Q_MAX)) begin
				sum = longint'(plint_pkg::Q_MAX);
				a.sat = 1'b1;
			end else if (sum < longint'(plint_pkg::Q_MIN)) begin
				sum = longint'(plint_pkg::Q_MIN);
				a.sat = 1'b1;
			end
			a.y = sum[31:0];
		end
		return a;
	endfunction

	// Expectation is queued when the command is presented; its result cannot precede acceptance.
	task automatic issue_command(input logic cmd_op, input logic [5:0] idx,
			input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [31:0] qx);
		answer_t a;
		if (cmd_op == plint_pkg::OP_LOAD) begin
			knot_x[idx] = px;
			knot_y[idx] = py;
			a = '0;
		end else begin
			a = interpolate_at(qx);
		end
		pending_answers.push_back(a);
		start <= 1'b1;
		op <= cmd_op;
		point_index <= idx;
		point_x <= px;
		point_y <= py;
		query_x <= qx;
		items_sent++;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_gap();
		while (gaps_on && $urandom_range(99) < 26) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic load_point(input logic [5:0] idx, input logic signed [31:0] px,
			input logic signed [31:0] py);
		issue_command(plint_pkg::OP_LOAD, idx, px, py, $urandom);
		idle_gap();
	endtask

	task automatic query_point(input logic signed [31:0] qx);
		issue_command(plint_pkg::OP_QUERY, 6'($urandom), $urandom, $urandom, qx);
		idle_gap();
	endtask

	// drop start and wait for every answer; every command yields one, so the block is then idle
	task automatic settle();
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_point_count(input logic [6:0] value);
		logic [31:0] word;
		word = $urandom;
		word[6:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= COUNT_ADDR;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		count_reg = value;
		// read back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[6:0] !== value)
			report_mismatch($sformatf("point_count read %0d, wrote %0d", prdata[6:0], value));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing outstanding, y=%h", result_y));
			end else begin
				want = pending_answers.pop_front();
				if (result_y !== want.y)
					report_mismatch($sformatf("result_y %h, want %h", result_y, want.y));
				if (is_query_result !== want.is_query)
					report_mismatch($sformatf("is_query_result %b, want %b",
						is_query_result, want.is_query));
				if (saturated !== want.sat)
					report_mismatch($sformatf("saturated %b, want %b", saturated, want.sat));
			end
		end
	end

	// point count 1 after reset: the only point answers every query
	task automatic test_single_point();
		load_point(6'd0, plint_pkg::Q_MIN, plint_pkg::Q_MAX);
		query_point(plint_pkg::Q_MAX);
		query_point(plint_pkg::Q_MIN);
	endtask

	// four points loaded out of order: interior, exact hits, both extrapolation sides
	task automatic test_four_point_table();
		settle();
		write_point_count(7'd4);
		load_point(6'd2, 32'sh0001_0000, 32'sh0000_8000);
		load_point(6'd0, 32'sh0003_0000, 32'sh000A_0000);
		load_point(6'd3, 32'sh0005_0000, plint_pkg::Q_MAX);
		load_point(6'd1, 32'shFFFF_0000, 32'shFFEC_0000);
		query_point(32'sh0001_0000);
		query_point(32'sh0000_0000);
		query_point(32'sh0004_0000);
		query_point(32'sh0005_0000);
		query_point(32'shFFFF_0000);
		query_point(plint_pkg::Q_MIN);
		query_point(plint_pkg::Q_MAX);
	endtask

	// duplicate x: bracket collapses, upper ordinate returned
	task automatic test_equal_abscissae();
		load_point(6'd1, 32'sh0003_0000, 32'shFFF9_0000);
		settle();
		write_point_count(7'd2);
		query_point(32'sh0000_0000);
		query_point(32'sh0003_0000);
		query_point(32'sh7FFF_0000);
	endtask

	function automatic logic signed [31:0] pick_query(input int n);
		int a, b;
		a = $urandom_range(n - 1);
		b = $urandom_range(n - 1);
		case ($urandom_range(5))
			0: return knot_x[a];
			1: return knot_x[a] + $urandom_range(1, 4095);
			2: return knot_x[a] - 1;
			3: return $urandom_range(1) ? plint_pkg::Q_MAX : plint_pkg::Q_MIN;
			4: return $urandom;
			default: return 32'((longint'(knot_x[a]) + longint'(knot_x[b])) >>> 1);
		endcase
	endfunction

	// each pass: new point count, full table in shuffled order, then queries with stray loads
	task automatic test_random_tables();
		int unsigned count_plan[8] = '{0, 1, 2, 64, 127, 3, 65, 5};
		int first, pass, c, n, k, j, tmp, style, base, step;
		int order[SLOTS];
		logic signed [31:0] xs[SLOTS];
		logic signed [31:0] ys[SLOTS];
		first = items_sent;
		pass = 0;
		while (items_sent - first < 400) begin
			settle();
			gaps_on = !((items_sent - first) >= 150 && (items_sent - first) < 260);
			if (pass < 8)
				c = count_plan[pass];
			else if ($urandom_range(9) < 7)
				c = $urandom_range(2, 8);
			else if ($urandom_range(1))
				c = $urandom_range(9, 32);
			else
				c = $urandom_range(33, 127);
			pass++;
			write_point_count(7'(c));
			n = slots_in_use();
			style = $urandom_range(3);
			base = int'($urandom_range(0, 1 << 20)) - (1 << 19);
			step = $urandom_range(1, 1 << 18);
			for (int i = 0; i < n; i++) begin
				case (style)
					0: xs[i] = $urandom;
					1: xs[i] = base + i * step;
					2: xs[i] = (i > 0 && $urandom_range(3) == 0) ? xs[i-1] : base + i * step;
					default: xs[i] = int'($urandom_range(255)) - 128;
				endcase
				ys[i] = $urandom_range(1) ? $urandom : int'($urandom_range(0, 1 << 21)) - (1 << 20);
				order[i] = i;
			end
			for (int i = n - 1; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
			for (int i = 0; i < n; i++)
				load_point(6'(order[i]), xs[order[i]], ys[order[i]]);
			k = $urandom_range(6, 14);
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(99) < 15)
					load_point(6'($urandom), $urandom, $urandom);
				else
					query_point(pick_query(n));
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		op <= plint_pkg::OP_LOAD;
		point_index <= '0;
		point_x <= '0;
		point_y <= '0;
		query_x <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_single_point();
		test_four_point_table();
		test_equal_abscissae();
		test_random_tables();

		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		// catch any stray beat
		repeat (120) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
